@@ rtl/caa_pkg.sv @@
package caa_pkg;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_RESIZE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Which run the write sequencer walks
  typedef enum logic [1:0] {
    RUN_MARK_NEW  = 2'd0,
    RUN_CLR_OLD   = 2'd1,
    RUN_CLR_TAIL  = 2'd2
  } run_sel_t;

  // Source of the placed start in the result
  typedef enum logic [1:0] {
    PL_ZERO  = 2'd0,
    PL_START = 2'd1,
    PL_FOUND = 2'd2
  } place_sel_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       run_start;
    run_sel_t   run_sel;
    logic       res_load;
    logic [1:0] res_status;
    place_sel_t res_sel;
  } caa_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       rl_zero;
    logic       nl_zero;
    logic       shrink;
    logic       range_bad;
    logic       init_busy;
    logic       scan_active;
    logic       found;
    logic       run_busy;
    logic       out_busy;
  } caa_stat_t;

endpackage

@@ rtl/contiguous_block_allocator.sv @@
// Flow: an item without map work goes from decode straight to the result register;
//   a first-fit scan and each run mark or clear come first, walking one block per
//   cycle (grow: scan, mark new run, then clear old run).
// One item at a time: no new item is taken until the result of the last is loaded.
// Reset: synchronous; then a clearing pass over every block with in_stall held high.
module contiguous_block_allocator
  import caa_pkg::*;
#(
  parameter int NUM_BLOCKS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [6:0] run_start,
  input  logic [6:0] run_length,
  input  logic [6:0] new_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [6:0] placed_start
);

  caa_cmd_t  cmd;
  caa_stat_t stat;

  caa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  caa_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (command),
    .run_start    (run_start),
    .run_length   (run_length),
    .new_length   (new_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .placed_start (placed_start)
  );

endmodule

@@ rtl/caa_dp.sv @@
module caa_dp
  import caa_pkg::*;
#(
  parameter int NUM_BLOCKS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  caa_cmd_t   cmd,
  output caa_stat_t  stat,
  input  logic [1:0] command,
  input  logic [6:0] run_start,
  input  logic [6:0] run_length,
  input  logic [6:0] new_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [6:0] placed_start
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = ((AW > 7) ? AW : 7) + 1;
  localparam logic [AW-1:0] LAST_BLK = AW'(NUM_BLOCKS - 1);

  // latched item fields
  logic [1:0] cmd_q;
  logic [6:0] rs_q;
  logic [6:0] rl_q;
  logic [6:0] nl_q;

  // block map memory, set = used
  logic          mem [NUM_BLOCKS];
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic          wr_data;
  logic [AW-1:0] rd_addr;
  logic          rd_q;

  // clearing pass
  logic          init_busy;
  logic [AW-1:0] init_addr;

  // scan
  logic          scan_active;
  logic          issue_on;
  logic [AW-1:0] scan_addr;
  logic          rd_valid;
  logic [AW-1:0] blk_q;
  logic [6:0]    count;
  logic [6:0]    count_next;
  logic [6:0]    scan_len;
  logic          hit;
  logic [CW-1:0] hit_start;
  logic          found_q;
  logic [CW-1:0] start_q;

  // run write sequencer
  logic [AW-1:0] run_addr;
  logic [6:0]    run_rem;
  logic          run_val;
  logic [CW-1:0] tail_addr;
  logic          run_busy;

  // result
  logic [6:0] placed_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      rs_q  <= run_start;
      rl_q  <= run_length;
      nl_q  <= new_length;
    end
  end

  assign scan_len  = (cmd_q == CMD_ALLOC) ? rl_q : nl_q;
  assign tail_addr = CW'(rs_q) + CW'(nl_q);
  assign run_busy  = (run_rem != 7'd0);

  // memory ports
  always_comb begin
    if (init_busy) begin
      mem_we  = 1'b1;
      wr_addr = init_addr;
      wr_data = (init_addr == '0);
    end else begin
      mem_we  = run_busy && !(run_addr == '0 && !run_val);
      wr_addr = run_addr;
      wr_data = run_val;
    end
  end

  assign rd_addr = scan_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      init_addr <= '0;
    end else if (init_busy) begin
      if (init_addr == LAST_BLK) begin
        init_busy <= 1'b0;
      end else begin
        init_addr <= init_addr + AW'(1);
      end
    end
  end

  // read for block b issues in the cycle before its use
  assign count_next = rd_q ? 7'd0 : count + 7'd1;
  assign hit        = rd_valid && (count_next == scan_len);
  assign hit_start  = CW'(blk_q) + CW'(1) - CW'(scan_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      issue_on    <= 1'b0;
      rd_valid    <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_active <= 1'b1;
      issue_on    <= 1'b1;
      rd_valid    <= 1'b0;
    end else if (scan_active) begin
      rd_valid <= issue_on;
      if (issue_on && scan_addr == LAST_BLK) begin
        issue_on <= 1'b0;
      end
      if (rd_valid && (hit || blk_q == LAST_BLK)) begin
        scan_active <= 1'b0;
        issue_on    <= 1'b0;
        rd_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
      count     <= 7'd0;
      found_q   <= 1'b0;
    end else if (scan_active) begin
      if (issue_on) begin
        blk_q <= scan_addr;
        if (scan_addr != LAST_BLK) begin
          scan_addr <= scan_addr + AW'(1);
        end
      end
      if (rd_valid) begin
        count   <= count_next;
        found_q <= hit;
        start_q <= hit_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_rem <= 7'd0;
    end else if (cmd.run_start) begin
      case (cmd.run_sel)
        RUN_MARK_NEW: begin
          run_addr <= start_q[AW-1:0];
          run_rem  <= scan_len;
          run_val  <= 1'b1;
        end
        RUN_CLR_OLD: begin
          run_addr <= CW'(rs_q) >= CW'(NUM_BLOCKS) ? '0 : AW'(CW'(rs_q));
          run_rem  <= rl_q;
          run_val  <= 1'b0;
        end
        RUN_CLR_TAIL: begin
          run_addr <= tail_addr[AW-1:0];
          run_rem  <= rl_q - nl_q;
          run_val  <= 1'b0;
        end
        default: begin
          run_rem <= 7'd0;
          run_val <= 1'b0;
        end
      endcase
    end else if (run_busy) begin
      run_addr <= run_addr + AW'(1);
      run_rem  <= run_rem - 7'd1;
    end
  end

  always_comb begin
    case (cmd.res_sel)
      PL_START: placed_next = rs_q;
      PL_FOUND: placed_next = start_q[6:0];
      default:  placed_next = 7'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status       <= cmd.res_status;
      placed_start <= placed_next;
    end
  end

  always_comb begin
    stat.cmd         = cmd_q;
    stat.rl_zero     = (rl_q == 7'd0);
    stat.nl_zero     = (nl_q == 7'd0);
    stat.shrink      = (nl_q < rl_q);
    stat.range_bad   = (CW'(rs_q) + CW'(rl_q)) > CW'(NUM_BLOCKS);
    stat.init_busy   = init_busy;
    stat.scan_active = scan_active;
    stat.found       = found_q;
    stat.run_busy    = run_busy;
    stat.out_busy    = out_valid && out_stall;
  end

  // the reserved block is only ever written as used
  a_blk0_kept: assert property (@(posedge clk) disable iff (rst)
    (mem_we && wr_addr == '0) |-> wr_data)
    else $error("reserved block cleared");

  a_scan_run_excl: assert property (@(posedge clk) disable iff (rst)
    !(scan_active && run_busy))
    else $error("scan overlaps run write");

  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !(scan_active || run_busy || cmd.load))
    else $error("activity during clearing pass");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(out_valid && out_stall))
    else $error("result overwrites pending item");

endmodule

@@ rtl/caa_ctrl.sv @@
module caa_ctrl
  import caa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  caa_stat_t stat,
  output caa_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_MARK   = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_REPLY  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_status, res_status_next;
  place_sel_t res_sel, res_sel_next;

  assign in_stall = (state != S_IDLE) || stat.init_busy;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_sel_next    = res_sel;
    cmd             = '0;
    cmd.run_sel     = RUN_CLR_OLD;
    cmd.res_sel     = res_sel;
    cmd.res_status  = res_status;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_next = ST_DONE;
        res_sel_next    = PL_ZERO;
        state_next      = S_REPLY;
        if (stat.cmd == CMD_ALLOC) begin
          if (!stat.rl_zero) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (stat.cmd == CMD_FREE || stat.cmd == CMD_RESIZE) begin
          if (stat.range_bad) begin
            res_status_next = ST_RANGE;
          end else if (stat.cmd == CMD_FREE) begin
            cmd.run_start = 1'b1;
            cmd.run_sel   = RUN_CLR_OLD;
            state_next    = S_CLEAR;
          end else if (stat.shrink) begin
            cmd.run_start = 1'b1;
            cmd.run_sel   = RUN_CLR_TAIL;
            res_sel_next  = PL_START;
            state_next    = S_CLEAR;
          end else if (!stat.nl_zero) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!stat.scan_active) begin
          if (stat.found) begin
            cmd.run_start = 1'b1;
            cmd.run_sel   = RUN_MARK_NEW;
            res_sel_next  = PL_FOUND;
            state_next    = S_MARK;
          end else begin
            res_status_next = ST_NOSPACE;
            state_next      = S_REPLY;
          end
        end
      end
      S_MARK: begin
        if (!stat.run_busy) begin
          if (stat.cmd == CMD_RESIZE) begin
            // old run is cleared only after the new one is marked
            cmd.run_start = 1'b1;
            cmd.run_sel   = RUN_CLR_OLD;
            state_next    = S_CLEAR;
          end else begin
            state_next = S_REPLY;
          end
        end
      end
      S_CLEAR: begin
        if (!stat.run_busy) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_DONE;
      res_sel    <= PL_ZERO;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_sel    <= res_sel_next;
    end
  end

  a_scan_from_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> state == S_DECODE)
    else $error("scan started outside decode");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DECODE)
    else $error("accepted item not decoded");

  a_reply_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> state == S_IDLE)
    else $error("result load left controller busy");

endmodule

@@ tb/sv/contiguous_block_allocator_checker.sv @@
module contiguous_block_allocator_checker
  import caa_pkg::*;
#(
  parameter int NUM_BLOCKS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  command,
  input  logic [6:0]  run_start,
  input  logic [6:0]  run_length,
  input  logic [6:0]  new_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [6:0]  placed_start,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] placed;
  } placement_t;

  // set = block in use
  logic [NUM_BLOCKS-1:0] used_blocks;
  placement_t            expected_placements[$];

  function automatic void mark_blocks(input int unsigned first, input int unsigned len,
                                      input logic value);
    int unsigned b;
    for (int unsigned k = 0; k < len; k++) begin
      b = first + k;
      // block 0 is reserved and never cleared
      if (b < NUM_BLOCKS && (b != 0 || value))
        used_blocks[b] = value;
    end
  endfunction

  function automatic bit first_fit(input int unsigned len, output int unsigned first);
    int unsigned count;
    count = 0;
    first = 0;
    for (int unsigned b = 0; b < NUM_BLOCKS; b++) begin
      count = used_blocks[b] ? 0 : count + 1;
      if (count == len) begin
        first = b + 1 - len;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic placement_t place_request(input logic [1:0] cmd, input logic [6:0] start,
                                               input logic [6:0] length,
                                               input logic [6:0] target);
    placement_t  res;
    int unsigned found;
    int unsigned rs;
    int unsigned rl;
    int unsigned nl;
    res.status = ST_DONE;
    res.placed = '0;
    rs = start;
    rl = length;
    nl = target;
    case (cmd)
      CMD_ALLOC: begin
        if (rl != 0) begin
          if (first_fit(rl, found)) begin
            mark_blocks(found, rl, 1'b1);
            res.placed = 7'(found);
          end else begin
            res.status = ST_NOSPACE;
          end
        end
      end
      CMD_FREE, CMD_RESIZE: begin
        if (rs + rl > NUM_BLOCKS) begin
          res.status = ST_RANGE;
        end else if (cmd == CMD_FREE) begin
          mark_blocks(rs, rl, 1'b0);
        end else if (nl < rl) begin
          mark_blocks(rs + nl, rl - nl, 1'b0);
          res.placed = 7'(rs);
        end else if (nl != 0) begin
          // new run is marked before the old one is cleared, overlap or not
          if (first_fit(nl, found)) begin
            mark_blocks(found, nl, 1'b1);
            mark_blocks(rs, rl, 1'b0);
            res.placed = 7'(found);
          end else begin
            res.status = ST_NOSPACE;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : check_items
    placement_t want;
    if (rst) begin
      used_blocks    = '0;
      used_blocks[0] = 1'b1;
      expected_placements.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_placements.insert(expected_placements.size(),
                                   place_request(command, run_start, run_length,
                                                 new_length));
      if (out_valid && !out_stall) begin
        if (expected_placements.size() == 0) begin
          $error("unexpected item: status %0d, placed_start %0d", status, placed_start);
          fail_count++;
        end else begin
          want = expected_placements.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (placed_start !== want.placed) begin
            $error("placed_start: expected %0d, actual %0d", want.placed, placed_start);
            fail_count++;
          end
        end
      end
      pending <= expected_placements.size();
    end
  end

endmodule

@@ tb/sv/contiguous_block_allocator_tb.sv @@
module contiguous_block_allocator_tb;
  import caa_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         RANDOM_ITEMS = 1300;

  typedef struct {
    logic [6:0] start;
    logic [6:0] len;
  } block_run_t;

  typedef struct {
    logic [1:0] cmd;
    block_run_t old_run;
    logic [6:0] target;
    bit         from_pool;
  } issued_item_t;

  logic       clk;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [1:0] command    = CMD_ALLOC;
  logic [6:0] run_start  = '0;
  logic [6:0] run_length = '0;
  logic [6:0] new_length = '0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [1:0] status;
  logic [6:0] placed_start;

  int unsigned fail_count;
  int unsigned pending;
  bit          idling = 1'b1;

  // runs known to be held, used to build well-formed free and resize items
  block_run_t   live_runs[$];
  issued_item_t issued_items[$];

  contiguous_block_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .run_start    (run_start),
    .run_length   (run_length),
    .new_length   (new_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .placed_start (placed_start)
  );

  contiguous_block_allocator_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .run_start    (run_start),
    .run_length   (run_length),
    .new_length   (new_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .placed_start (placed_start),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // follow results so that later items can target runs that are really held
  always @(posedge clk) begin : track_runs
    issued_item_t it;
    if (!rst && out_valid && !out_stall && issued_items.size() != 0) begin
      it = issued_items.pop_front();
      if (it.cmd == CMD_ALLOC && status == ST_DONE && placed_start != 0) begin
        live_runs.insert(live_runs.size(), '{placed_start, it.old_run.len});
      end else if (it.cmd == CMD_RESIZE) begin
        if (status == ST_DONE) begin
          if (it.target < it.old_run.len) begin
            if (it.from_pool && it.target != 0)
              live_runs.insert(live_runs.size(), '{it.old_run.start, it.target});
          end else if (it.target != 0) begin
            live_runs.insert(live_runs.size(), '{placed_start, it.target});
          end
        end else if (it.from_pool) begin
          live_runs.insert(live_runs.size(), it.old_run);
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [6:0] start,
                           input logic [6:0] length, input logic [6:0] target,
                           input bit from_pool);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    run_start  <= start;
    run_length <= length;
    new_length <= target;
    do @(posedge clk); while (in_stall);
    issued_items.insert(issued_items.size(), '{cmd, '{start, length}, target, from_pool});
  endtask

  task automatic send_random_item();
    block_run_t r;
    int         idx;
    logic [6:0] start;
    logic [6:0] length;
    logic [6:0] target;
    if ($urandom_range(0, 4) == 0) begin
      // noise: any field values, command 3 and out-of-range runs included
      start  = 7'($urandom_range(0, 127));
      length = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 127 - start))
                                           : 7'($urandom_range(0, 127));
      send_item(2'($urandom_range(0, 3)), start, length, 7'($urandom_range(0, 127)), 1'b0);
    end else if (live_runs.size() == 0 ||
                 $urandom_range(0, 99) < (live_runs.size() < 12 ? 60 : 25)) begin
      length = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(11, 127))
                                            : 7'($urandom_range(1, 10));
      send_item(CMD_ALLOC, 7'($urandom_range(0, 127)), length, 7'($urandom_range(0, 127)),
                1'b0);
    end else begin
      idx = $urandom_range(0, live_runs.size() - 1);
      r   = live_runs[idx];
      live_runs.delete(idx);
      if ($urandom_range(0, 1) == 0) begin
        send_item(CMD_FREE, r.start, r.len, 7'($urandom_range(0, 127)), 1'b1);
      end else begin
        if ($urandom_range(0, 1) == 0)
          target = 7'($urandom_range(0, r.len - 1));
        else
          target = (int'(r.len) + 12 > 127) ? 7'($urandom_range(r.len, 127))
                                            : 7'(r.len + $urandom_range(0, 12));
        send_item(CMD_RESIZE, r.start, r.len, target, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_ALLOC,  7'd0,   7'd0,   7'd0,   1'b0);  // zero length
    send_item(CMD_ALLOC,  7'd0,   7'd127, 7'd0,   1'b0);  // whole map
    send_item(CMD_ALLOC,  7'd0,   7'd1,   7'd0,   1'b0);  // map full
    send_item(CMD_FREE,   7'd127, 7'd2,   7'd0,   1'b0);  // past last block
    send_item(CMD_FREE,   7'd1,   7'd127, 7'd0,   1'b0);  // ends exactly at last block
    send_item(CMD_FREE,   7'd0,   7'd1,   7'd0,   1'b0);  // reserved block stays
    send_item(CMD_ALLOC,  7'd0,   7'd1,   7'd0,   1'b0);
    send_item(CMD_RESIZE, 7'd3,   7'd2,   7'd2,   1'b0);  // unmarked old run overlaps new
    send_item(CMD_RESIZE, 7'd1,   7'd1,   7'd0,   1'b0);  // shrink to nothing
    send_item(CMD_RESIZE, 7'd5,   7'd0,   7'd0,   1'b0);  // zero to zero
    send_item(CMD_UNUSED, 7'd127, 7'd127, 7'd127, 1'b0);
    send_item(CMD_ALLOC,  7'd0,   7'd4,   7'd0,   1'b0);
    send_item(CMD_ALLOC,  7'd0,   7'd4,   7'd0,   1'b0);
    send_item(CMD_RESIZE, 7'd3,   7'd4,   7'd6,   1'b0);  // grow
    send_item(CMD_RESIZE, 7'd11,  7'd6,   7'd6,   1'b0);  // same size moves
    send_item(CMD_RESIZE, 7'd17,  7'd6,   7'd127, 1'b0);  // grow, no space
    send_item(CMD_RESIZE, 7'd120, 7'd10,  7'd1,   1'b0);  // past last block
    send_item(CMD_RESIZE, 7'd127, 7'd1,   7'd0,   1'b0);
    send_item(CMD_FREE,   7'd0,   7'd127, 7'd0,   1'b0);
    send_item(CMD_ALLOC,  7'd0,   7'd127, 7'd0,   1'b0);
    send_item(CMD_FREE,   7'd1,   7'd127, 7'd0,   1'b0);
    send_item(CMD_ALLOC,  7'd0,   7'd126, 7'd0,   1'b0);
    send_item(CMD_RESIZE, 7'd1,   7'd126, 7'd127, 1'b0);
    send_item(CMD_FREE,   7'd1,   7'd126, 7'd0,   1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0)
        idling = (n < RANDOM_ITEMS - 150) && ($urandom_range(0, 3) != 0);
      send_random_item();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
